### design/tlwh_pkg.sv
// Package for the target lock block: field widths, configuration register
// indexes and reset values. No dependencies.
`default_nettype none

package tlwh_pkg;

    localparam int ID_W      = 16;
    localparam int CONF_W    = 15;
    localparam int INDEX_W   = 6;
    localparam int FRAMES_W  = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 15;

    typedef logic signed [ID_W-1:0] det_id_t;
    typedef logic [CONF_W-1:0]      conf_t;
    typedef logic [INDEX_W-1:0]     index_t;
    typedef logic [FRAMES_W-1:0]    frames_t;
    typedef logic [CFG_IDX_W-1:0]   cfg_idx_t;
    typedef logic [CFG_DAT_W-1:0]   cfg_dat_t;

    // Configuration register indexes
    localparam cfg_idx_t REG_SWITCH_MARGIN = 2'd0;
    localparam cfg_idx_t REG_SWITCH_FRAMES = 2'd1;

    localparam conf_t   MARGIN_RESET = 15'd2560;
    localparam frames_t FRAMES_RESET = 8'd5;
    localparam frames_t COUNT_MAX    = 8'd255;
    localparam det_id_t NO_ID        = -16'sd1;

endpackage

`default_nettype wire

### design/target_lock_with_hysteresis.sv
// Top level of the target lock block: input register, per-detection update
// and frame-end decision, result register. Depends on tlwh_pkg.
//
//  Channel   Ports                                    Direction  Moves
//  s_        s_valid/s_ready, detection fields        in         one detection request
//  m_        m_valid/m_ready, selection fields        out        one result per frame end
//  cfg_      cfg_valid/cfg_ready, cfg_index/cfg_data  in         one register write
//
// One detection a cycle while the input register is not stalled. A request
// waits in the input register, then one pass of compare logic updates the
// frame state and, at frame end, loads the result register.
// The input register only stalls when a frame-end request meets a result
// that is still waiting downstream. Reset (aresetn, synchronous, active low)
// drops the lock, the challenger, the frame in progress and both registers.
`default_nettype none

module target_lock_with_hysteresis #(
    parameter int MAX_BODIES = 64
) (
    input  wire                    aclk,
    input  wire                    aresetn,

    input  wire                    s_valid,
    output logic                   s_ready,
    input  tlwh_pkg::det_id_t      s_det_id,
    input  tlwh_pkg::conf_t        s_det_confidence,
    input  wire                    s_frame_empty,
    input  wire                    s_last_in_frame,

    output logic                   m_valid,
    input  wire                    m_ready,
    output logic                   m_has_selection,
    output tlwh_pkg::index_t       m_chosen_index,
    output tlwh_pkg::det_id_t      m_locked_id_out,

    input  wire                    cfg_valid,
    output logic                   cfg_ready,
    input  tlwh_pkg::cfg_idx_t     cfg_index,
    input  tlwh_pkg::cfg_dat_t     cfg_data
);
    import tlwh_pkg::*;

    // Position counter holds 0..MAX_BODIES; stored positions hold 0..MAX_BODIES-1
    localparam int CNT_W = $clog2(MAX_BODIES + 1);
    localparam int POS_W = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_BODIES);

    // Configuration registers
    conf_t   switch_margin_reg;
    frames_t switch_frames_reg;

    // Input register
    logic    in_valid_reg;
    det_id_t in_id_reg;
    conf_t   in_conf_reg;
    logic    in_empty_reg;
    logic    in_last_reg;

    // Lock state across frames
    det_id_t locked_id_reg, locked_id_next;
    det_id_t chal_id_reg, chal_id_next;
    frames_t chal_count_reg, chal_count_next;

    // Frame state
    conf_t             best_conf_reg, best_conf_next;
    logic [POS_W-1:0]  best_pos_reg, best_pos_next;
    det_id_t           best_id_reg, best_id_next;
    logic              locked_found_reg, locked_found_next;
    logic [POS_W-1:0]  locked_pos_reg, locked_pos_next;
    conf_t             locked_conf_reg, locked_conf_next;
    logic [CNT_W-1:0]  item_pos_reg, item_pos_next;

    // Result register
    logic    m_valid_reg;
    logic    res_has_reg, res_has_next;
    index_t  res_index_reg, res_index_next;
    det_id_t res_lock_reg;

    // Per-item working values
    logic              frame_end;
    logic              advance;
    logic              take;
    logic              better;
    logic              lock_hit;
    conf_t             f_best_conf;
    logic [POS_W-1:0]  f_best_pos;
    det_id_t           f_best_id;
    logic              f_locked_found;
    logic [POS_W-1:0]  f_locked_pos;
    conf_t             f_locked_conf;
    logic [CNT_W-1:0]  f_item_pos;
    logic [CONF_W:0]   lock_plus_margin;
    logic [POS_W-1:0]  sel_pos;
    logic [POS_W+INDEX_W-1:0] sel_pos_ext;
    frames_t           count_bumped;

    // Handshake: a frame-end request waits for room in the result register
    assign frame_end = in_empty_reg | in_last_reg;
    assign advance   = in_valid_reg & (~frame_end | ~m_valid_reg | m_ready);
    assign s_ready   = ~in_valid_reg | advance;
    assign cfg_ready = 1'b1;

    assign m_valid         = m_valid_reg;
    assign m_has_selection = res_has_reg;
    assign m_chosen_index  = res_index_reg;
    assign m_locked_id_out = res_lock_reg;

    // Fold the current detection into the running best and the lock search
    always_comb begin
        take     = in_valid_reg & ~in_empty_reg & (item_pos_reg < CNT_LIMIT);
        better   = (item_pos_reg == '0) | (in_conf_reg > best_conf_reg);
        lock_hit = take & ~locked_id_reg[ID_W-1] & ~locked_found_reg
                 & (in_id_reg == locked_id_reg);

        f_best_conf    = best_conf_reg;
        f_best_pos     = best_pos_reg;
        f_best_id      = best_id_reg;
        f_locked_found = locked_found_reg;
        f_locked_pos   = locked_pos_reg;
        f_locked_conf  = locked_conf_reg;
        f_item_pos     = item_pos_reg;

        if (take) begin
            f_item_pos = item_pos_reg + 1'b1;
            if (better) begin
                f_best_conf = in_conf_reg;
                f_best_pos  = item_pos_reg[POS_W-1:0];
                f_best_id   = in_id_reg;
            end
        end
        if (lock_hit) begin
            f_locked_found = 1'b1;
            f_locked_pos   = item_pos_reg[POS_W-1:0];
            f_locked_conf  = in_conf_reg;
        end
    end

    // Frame-end decision on the updated frame state
    always_comb begin
        lock_plus_margin = {1'b0, f_locked_conf} + {1'b0, switch_margin_reg};
        count_bumped     = (chal_count_reg < COUNT_MAX) ? chal_count_reg + 1'b1
                                                        : chal_count_reg;

        locked_id_next  = locked_id_reg;
        chal_id_next    = chal_id_reg;
        chal_count_next = chal_count_reg;
        res_has_next    = 1'b1;
        sel_pos         = f_locked_pos;

        priority if (f_item_pos == '0) begin
            // Empty frame: drop everything
            locked_id_next  = NO_ID;
            chal_id_next    = NO_ID;
            chal_count_next = '0;
            res_has_next    = 1'b0;
            sel_pos         = '0;
        end else if (f_best_id[ID_W-1]) begin
            // Untracked best: drop the lock, still emit the best
            locked_id_next  = NO_ID;
            chal_id_next    = NO_ID;
            chal_count_next = '0;
            sel_pos         = f_best_pos;
        end else if (!f_locked_found) begin
            // Locked target gone: lock onto the best
            locked_id_next  = f_best_id;
            chal_id_next    = NO_ID;
            chal_count_next = '0;
            sel_pos         = f_best_pos;
        end else if (f_best_id == locked_id_reg
                     || {1'b0, f_best_conf} < lock_plus_margin) begin
            // Lock holds its place
            chal_id_next    = NO_ID;
            chal_count_next = '0;
        end else begin
            // Clearly better challenger: count its leading frames
            if (chal_id_reg == f_best_id) begin
                chal_count_next = count_bumped;
            end else begin
                chal_count_next = frames_t'(1);
            end
            chal_id_next = f_best_id;
            if (chal_count_next >= switch_frames_reg) begin
                locked_id_next  = f_best_id;
                chal_id_next    = NO_ID;
                chal_count_next = '0;
                sel_pos         = f_best_pos;
            end
        end

        sel_pos_ext    = {{INDEX_W{1'b0}}, sel_pos};
        res_index_next = sel_pos_ext[INDEX_W-1:0];
    end

    // Next frame state: clear at frame end, else carry the updated values
    always_comb begin
        if (frame_end) begin
            best_conf_next    = '0;
            best_pos_next     = '0;
            best_id_next      = NO_ID;
            locked_found_next = 1'b0;
            locked_pos_next   = '0;
            locked_conf_next  = '0;
            item_pos_next     = '0;
        end else begin
            best_conf_next    = f_best_conf;
            best_pos_next     = f_best_pos;
            best_id_next      = f_best_id;
            locked_found_next = f_locked_found;
            locked_pos_next   = f_locked_pos;
            locked_conf_next  = f_locked_conf;
            item_pos_next     = f_item_pos;
        end
    end

    // Configuration writes; indexes past the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            switch_margin_reg <= MARGIN_RESET;
            switch_frames_reg <= FRAMES_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_SWITCH_MARGIN: switch_margin_reg <= cfg_data;
                REG_SWITCH_FRAMES: switch_frames_reg <= cfg_data[FRAMES_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register: load on accept, empty once the request moves on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_id_reg    <= s_det_id;
            in_conf_reg  <= s_det_confidence;
            in_empty_reg <= s_frame_empty;
            in_last_reg  <= s_last_in_frame;
        end
    end

    // Frame state advances with each request that moves on; lock state at frame end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            locked_id_reg    <= NO_ID;
            chal_id_reg      <= NO_ID;
            chal_count_reg   <= '0;
            best_conf_reg    <= '0;
            best_pos_reg     <= '0;
            best_id_reg      <= NO_ID;
            locked_found_reg <= 1'b0;
            locked_pos_reg   <= '0;
            locked_conf_reg  <= '0;
            item_pos_reg     <= '0;
        end else if (advance) begin
            best_conf_reg    <= best_conf_next;
            best_pos_reg     <= best_pos_next;
            best_id_reg      <= best_id_next;
            locked_found_reg <= locked_found_next;
            locked_pos_reg   <= locked_pos_next;
            locked_conf_reg  <= locked_conf_next;
            item_pos_reg     <= item_pos_next;
            if (frame_end) begin
                locked_id_reg  <= locked_id_next;
                chal_id_reg    <= chal_id_next;
                chal_count_reg <= chal_count_next;
            end
        end
    end

    // Result register: hold until taken downstream
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && frame_end) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && frame_end) begin
            res_has_reg   <= res_has_next;
            res_index_reg <= res_index_next;
            res_lock_reg  <= locked_id_next;
        end
    end

endmodule

`default_nettype wire

### design/tlwh_checker.sv
// Port-level checker for the target lock block, bound to the top level.
// Depends on tlwh_pkg.
`default_nettype none

module tlwh_checker (
    input wire                  aclk,
    input wire                  aresetn,
    input wire                  m_valid,
    input wire                  m_ready,
    input wire                  m_has_selection,
    input tlwh_pkg::index_t     m_chosen_index,
    input tlwh_pkg::det_id_t    m_locked_id_out
);
    import tlwh_pkg::*;

    // No result straight after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result shown after reset");

    // A frame without a selection leaves no lock and index zero
    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_has_selection) |-> (m_chosen_index == '0
                                           && m_locked_id_out == NO_ID))
        else $error("empty frame result carries a lock or index");

    // Lock id is either none or a tracked id
    a_lock_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_locked_id_out[ID_W-1] || m_locked_id_out == NO_ID))
        else $error("locked id is an untracked value other than none");

    // Stalled result holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_has_selection)
                                   && $stable(m_chosen_index)
                                   && $stable(m_locked_id_out)))
        else $error("stalled result changed");

endmodule

bind target_lock_with_hysteresis tlwh_checker u_tlwh_checker (.*);

`default_nettype wire
